### rtl/sli_pkg.sv
package sli_pkg;

  // Default list capacity.
  localparam int CAPACITY_DEF = 16;

  localparam int KEY_W = 16;
  localparam int PAY_W = 8;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic ins_go;
    logic rd_empty;
    logic rd_entry;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic empty;
    logic rd_last;
  } dp_status_t;

endpackage

### rtl/sli_in_if.sv
interface sli_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [sli_pkg::KEY_W-1:0] key_in;
  logic [sli_pkg::PAY_W-1:0] payload_in;

  modport source (output valid, output cmd, output key_in, output payload_in, input ready);
  modport sink (input valid, input cmd, input key_in, input payload_in, output ready);
endinterface

### rtl/sli_out_if.sv
interface sli_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [sli_pkg::KEY_W-1:0] key_out;
  logic [sli_pkg::PAY_W-1:0] payload_out;
  logic                      last;

  modport source (output valid, output status, output key_out, output payload_out,
                  output last, input ready);
  modport sink (input valid, input status, input key_out, input payload_out,
                input last, output ready);
endinterface

### rtl/sli_ctrl.sv
module sli_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  input  sli_pkg::dp_status_t st,
  output sli_pkg::ctl_cmd_t   cmd
);

  sli_pkg::state_t state_r;
  sli_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sli_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sli_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (sli_pkg::cmd_t'(in_cmd)) inside
            sli_pkg::CMD_APPEND, sli_pkg::CMD_INSERT: state_nxt = sli_pkg::S_INS;
            sli_pkg::CMD_READ:                        state_nxt = sli_pkg::S_READ;
            default:                                  state_nxt = sli_pkg::S_IDLE;
          endcase
        end
      end
      sli_pkg::S_INS: begin
        if (st.slot_free) begin
          state_nxt = sli_pkg::S_IDLE;
        end
      end
      sli_pkg::S_READ: begin
        if (st.slot_free && (st.empty || st.rd_last)) begin
          state_nxt = sli_pkg::S_IDLE;
        end
      end
      default: state_nxt = sli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == sli_pkg::S_IDLE);
    cmd.accept   = in_ready && in_valid;
    cmd.ins_go   = (state_r == sli_pkg::S_INS) && st.slot_free;
    cmd.rd_empty = (state_r == sli_pkg::S_READ) && st.slot_free && st.empty;
    cmd.rd_entry = (state_r == sli_pkg::S_READ) && st.slot_free && !st.empty;
  end

endmodule

### rtl/sli_dp.sv
module sli_dp #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sli_pkg::ctl_cmd_t         cmd,
  output sli_pkg::dp_status_t       st,
  input  logic [1:0]                in_cmd,
  input  logic [sli_pkg::KEY_W-1:0] in_key,
  input  logic [sli_pkg::PAY_W-1:0] in_payload,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [sli_pkg::KEY_W-1:0] out_key,
  output logic [sli_pkg::PAY_W-1:0] out_payload,
  output logic                      out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  // Entry cells, head at index 0.
  logic [sli_pkg::KEY_W-1:0] key_r   [CAPACITY];
  logic [sli_pkg::PAY_W-1:0] pay_r   [CAPACITY];
  logic [sli_pkg::KEY_W-1:0] key_nxt [CAPACITY];
  logic [sli_pkg::PAY_W-1:0] pay_nxt [CAPACITY];

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [CAPACITY-1:0]       ge_r, ge_nxt;
  logic [CAPACITY-1:0]       after_pos;
  logic                      any_ge;
  logic                      full;
  logic [sli_pkg::KEY_W-1:0] new_key_r;
  logic [sli_pkg::PAY_W-1:0] new_pay_r;

  logic                      out_valid_r, out_valid_nxt;
  sli_pkg::status_t          status_r, status_nxt;
  logic [sli_pkg::KEY_W-1:0] key_out_r, key_out_nxt;
  logic [sli_pkg::PAY_W-1:0] pay_out_r, pay_out_nxt;
  logic                      last_r, last_nxt;
  logic                      load;

  assign full          = (count_r == CNT_W'(CAPACITY));
  assign any_ge        = |ge_r;
  assign st.slot_free  = !out_valid_r || out_ready;
  assign st.empty      = (count_r == '0);
  assign st.rd_last    = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign load          = cmd.ins_go || cmd.rd_empty || cmd.rd_entry;

  // For an insert, each valid cell compares its key with the new one when the item arrives.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ge_nxt[i] = (sli_pkg::cmd_t'(in_cmd) == sli_pkg::CMD_INSERT) &&
                  (CNT_W'(i) < count_r) && (key_r[i] >= in_key);
      after_pos[i] = |(ge_r & ({CAPACITY{1'b1}} >> (CAPACITY - i)));
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [sli_pkg::KEY_W-1:0] prev_key;
    logic [sli_pkg::PAY_W-1:0] prev_pay;
    logic                      rot_wrap;

    if (g == 0) begin : g_head
      assign prev_key = new_key_r;
      assign prev_pay = new_pay_r;
    end else begin : g_body
      assign prev_key = key_r[g-1];
      assign prev_pay = pay_r[g-1];
    end

    assign rot_wrap = (CNT_W'(g) == (count_r - CNT_W'(1))) || (g == CAPACITY - 1);

    always_comb begin
      key_nxt[g] = key_r[g];
      pay_nxt[g] = pay_r[g];
      if (cmd.ins_go && !full) begin
        if ((ge_r[g] && !after_pos[g]) || (!any_ge && CNT_W'(g) == count_r)) begin
          key_nxt[g] = new_key_r;
          pay_nxt[g] = new_pay_r;
        end else if (after_pos[g]) begin
          key_nxt[g] = prev_key;
          pay_nxt[g] = prev_pay;
        end
      end else if (cmd.rd_entry) begin
        // Rotate the occupied cells toward the head by one.
        if (rot_wrap) begin
          key_nxt[g] = key_r[0];
          pay_nxt[g] = pay_r[0];
        end else begin
          key_nxt[g] = key_r[(g + 1) % CAPACITY];
          pay_nxt[g] = pay_r[(g + 1) % CAPACITY];
        end
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    key_out_nxt   = key_out_r;
    pay_out_nxt   = pay_out_r;
    last_nxt      = last_r;

    if (cmd.accept) begin
      idx_nxt = '0;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
      key_out_nxt   = '0;
      pay_out_nxt   = '0;
      last_nxt      = 1'b1;
      status_nxt    = sli_pkg::ST_OK;
    end

    if (cmd.ins_go) begin
      if (full) begin
        status_nxt = sli_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.rd_empty) begin
      status_nxt = sli_pkg::ST_EMPTY;
    end

    if (cmd.rd_entry) begin
      key_out_nxt = key_r[0];
      pay_out_nxt = pay_r[0];
      last_nxt    = st.rd_last;
      idx_nxt     = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      ge_r        <= '0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.accept) begin
        ge_r <= ge_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_r[i] <= key_nxt[i];
      pay_r[i] <= pay_nxt[i];
    end
    if (cmd.accept) begin
      new_key_r <= in_key;
      new_pay_r <= in_payload;
    end
    status_r  <= status_nxt;
    key_out_r <= key_out_nxt;
    pay_out_r <= pay_out_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_key     = key_out_r;
  assign out_payload = pay_out_r;
  assign out_last    = last_r;

endmodule

### rtl/sorted_list_insert_top.sv
// Channel   Direction  Handshake     Payload
// in_ch     sink       valid/ready   cmd, key_in, payload_in
// out_ch    source     valid/ready   status, key_out, payload_out, last
//
// An append or a sorted insert has the transfer in, where for an insert every
// occupied cell compares its key with the new one, then the step that shifts
// the cells and loads the status result once the output register is free. A
// read-out has the transfer in, then emits the head cell and rotates the list
// by one for each stored entry (an empty status alone for an empty list).
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// A stall on out_ch holds the controller in place; no result is lost.

module sorted_list_insert_top #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input logic    clk,
  input logic    rst_n,
  sli_in_if.sink   in_ch,
  sli_out_if.source out_ch
);

  // Command and status between the controller and the cell datapath.
  sli_pkg::ctl_cmd_t   cmd;
  sli_pkg::dp_status_t st;

  // The controller sequences one command at a time; the next transfer in is
  // accepted while the previous result still waits in the output register.
  sli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the cell chain, the entry count and the output register.
  sli_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_cmd      (in_ch.cmd),
    .in_key      (in_ch.key_in),
    .in_payload  (in_ch.payload_in),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_key     (out_ch.key_out),
    .out_payload (out_ch.payload_out),
    .out_last    (out_ch.last)
  );

`ifndef SYNTH
  // At most one result is loaded per cycle.
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins_go, cmd.rd_empty, cmd.rd_entry}))
    else $error("more than one result loaded in a cycle");

  // A new transfer in never overlaps work on the previous command.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.ins_go || cmd.rd_empty || cmd.rd_entry))
    else $error("transfer in accepted while a command is in progress");

  // After the tail entry is read out the block is ready for the next command.
  a_ready_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_entry && st.rd_last) |=> in_ch.ready)
    else $error("not ready after the tail entry was read out");

  // A result only appears after the controller loaded one.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.ins_go || cmd.rd_empty || cmd.rd_entry))
    else $error("result valid without a load");
`endif

endmodule
